@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/tts_pkg.sv @@
// Package for the thread table scheduler: types, codes, sizes.
// No dependencies.
package tts_pkg;
  localparam int unsigned MaxThreadsDefault = 16;

  localparam logic [1:0] ModeCreate   = 2'd0;
  localparam logic [1:0] ModeSchedule = 2'd1;
  localparam logic [1:0] ModeYield    = 2'd2;
  localparam logic [1:0] ModeDestroy  = 2'd3;

  localparam logic [1:0] PolRr   = 2'd0;
  localparam logic [1:0] PolPrio = 2'd1;
  localparam logic [1:0] PolFcfs = 2'd2;

  localparam logic [1:0] StsOk      = 2'd0;
  localparam logic [1:0] StsFull    = 2'd1;
  localparam logic [1:0] StsNone    = 2'd2;
  localparam logic [1:0] StsIgnored = 2'd3;

  localparam logic [1:0] StFree  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StYield = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the event, clear scan state
    logic step;     // examine entry at cursor, advance
    logic finish;   // commit the event, produce result
  } tts_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done; // cursor walked past the last entry, or yield/destroy mode
  } tts_sts_t;
endpackage

@@ design/thread_table_scheduler.sv @@
// Thread table scheduler: one event in, one result out per transaction. An
// event passes through a load step, a serial scan of the slot table visiting
// one entry per step, and a commit step; yield and destroy skip the scan.
// The next event is taken once the result slot is free. The policy register
// must be written only while the block is idle; the block does not enforce it.
// Depends on tts_pkg, tts_ctrl, tts_dp and assert_macros.svh.
`include "assert_macros.svh"
module thread_table_scheduler #(
  parameter int unsigned MAX_THREADS = tts_pkg::MaxThreadsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  policy_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  priority_req_i,
  input  logic [31:0] create_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [4:0]  thread_id_o
);
  logic [1:0] policy_q;
  tts_pkg::tts_cmd_t cmd;
  tts_pkg::tts_sts_t sts;

  // Policy register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= tts_pkg::PolRr;
    else if (cfg_valid_i) policy_q <= policy_i;
  end

  tts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_i (out_valid_o), .out_ready_i,
    .sts_i (sts), .cmd_o (cmd)
  );

  tts_dp #(.MaxThreads(MAX_THREADS)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .policy_i (policy_q), .mode_i, .priority_req_i, .create_time_i,
    .out_valid_o, .out_ready_i, .status_o, .thread_id_o
  );

  `ASSERT_NEXT(a_result_after_commit, clk_i, rst_ni, cmd.finish, out_valid_o)
  `ASSERT_IMPL(a_no_accept_while_busy, clk_i, rst_ni, cmd.step || cmd.finish, !in_ready_o)
  `ASSERT_IMPL(a_id_zero_on_error, clk_i, rst_ni, out_valid_o && status_o != tts_pkg::StsOk, thread_id_o == 5'd0)
endmodule

@@ design/tts_ctrl.sv @@
// Controller for the thread table scheduler: sequences load, scan and commit.
// Depends on tts_pkg.
module tts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tts_pkg::tts_sts_t sts_i,
  output tts_pkg::tts_cmd_t cmd_o
);
  typedef enum logic [1:0] {SIdle, SScan, SDone} state_e;
  state_e state_q;

  // Accept only when idle and the output slot is free or leaving.
  assign in_ready_o = (state_q == SIdle) && (!out_valid_i || out_ready_i);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.step = (state_q == SScan);
    cmd_o.finish = (state_q == SDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      unique case (state_q)
        SIdle: if (in_valid_i && in_ready_o) state_q <= SScan;
        SScan: if (sts_i.scan_done) state_q <= SDone;
        SDone: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

@@ design/tts_dp.sv @@
// Datapath for the thread table scheduler: slot table, scan and commit logic.
// Depends on tts_pkg.
module tts_dp #(
  parameter int unsigned MaxThreads = tts_pkg::MaxThreadsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tts_pkg::tts_cmd_t cmd_i,
  output tts_pkg::tts_sts_t sts_o,
  input  logic [1:0]        policy_i,
  input  logic [1:0]        mode_i,
  input  logic [7:0]        priority_req_i,
  input  logic [31:0]       create_time_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [4:0]        thread_id_o
);
  localparam int unsigned Slots = MaxThreads + 1;
  localparam int unsigned IdW = $clog2(Slots + 1);

  logic [1:0]  state_q [Slots];
  logic [7:0]  prio_q  [Slots];
  logic [31:0] birth_q [Slots];
  logic [IdW-1:0] used_q, last_q, run_q;

  logic [1:0]  mode_q, pol_q;
  logic [7:0]  preq_q;
  logic [31:0] ctime_q;
  logic [IdW-1:0] i_q;       // scan step counter, 1..used+1
  logic [IdW-1:0] id_q;      // rr/prio cursor, slot visited this step
  logic           found_q;
  logic [IdW-1:0] best_q;

  // Slot visited: rr/prio walk from last+1 modulo used, fcfs/create from 1.
  logic [IdW-1:0] vis;
  logic [IdW-1:0] sum;
  logic           lim;
  logic           hit;
  logic           better;
  logic [IdW-1:0] bidx;
  assign sum = id_q + 1'b1;
  always_comb begin
    if (mode_q == tts_pkg::ModeSchedule &&
        (pol_q == tts_pkg::PolRr || pol_q == tts_pkg::PolPrio))
      vis = id_q;
    else
      vis = i_q;
  end
  assign bidx = best_q;
  always_comb begin
    hit = 1'b0;
    better = 1'b0;
    if (mode_q == tts_pkg::ModeCreate) begin
      hit = (state_q[vis] == tts_pkg::StFree) && !found_q;
      better = hit;
    end else if (vis != '0 && state_q[vis] == tts_pkg::StRun) begin
      hit = 1'b1;
      unique case (pol_q)
        tts_pkg::PolRr: better = !found_q;
        tts_pkg::PolPrio:
          better = !found_q || prio_q[bidx] < prio_q[vis] ||
                   (prio_q[bidx] == prio_q[vis] && birth_q[bidx] > birth_q[vis]);
        tts_pkg::PolFcfs: better = !found_q || birth_q[vis] < birth_q[bidx];
        default: better = 1'b0;
      endcase
    end
  end
  // Step limit: create/fcfs/rr visit i < used, prio visits i <= used.
  always_comb begin
    if (mode_q == tts_pkg::ModeSchedule && pol_q == tts_pkg::PolPrio)
      lim = (i_q > used_q);
    else
      lim = (i_q >= used_q);
  end
  assign sts_o.scan_done = lim || mode_q[1];

  // Commit decisions.
  logic           ld_ok;
  logic [IdW-1:0] nxt;
  logic           nxt_ok;
  always_comb begin
    ld_ok = (last_q != '0) &&
            (state_q[last_q] == tts_pkg::StRun || state_q[last_q] == tts_pkg::StYield);
    nxt_ok = found_q || ld_ok;
    nxt = found_q ? best_q : last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Slots; k++) state_q[k] <= tts_pkg::StFree;
      state_q[0] <= tts_pkg::StRun;
      used_q <= IdW'(1);
      last_q <= '0;
      run_q <= '0;
      out_valid_o <= 1'b0;
      found_q <= 1'b0;
      i_q <= '0;
      id_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.load) begin
        mode_q <= mode_i;
        pol_q <= policy_i;
        preq_q <= priority_req_i;
        ctime_q <= create_time_i;
        found_q <= 1'b0;
        i_q <= IdW'(1);
        // first visited id = (last+1) % used
        id_q <= ((last_q + 1'b1) >= used_q) ? '0 : last_q + 1'b1;
      end else if (cmd_i.step && !sts_o.scan_done) begin
        if (hit && better) begin
          found_q <= 1'b1;
          best_q <= vis;
        end
        i_q <= i_q + 1'b1;
        id_q <= (sum >= used_q) ? '0 : sum;
      end else if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
        status_o <= tts_pkg::StsOk;
        thread_id_o <= '0;
        unique case (mode_q)
          tts_pkg::ModeCreate: begin
            if (found_q || used_q <= IdW'(MaxThreads)) begin
              if (!found_q) used_q <= used_q + 1'b1;
              state_q[found_q ? best_q : used_q] <= tts_pkg::StRun;
              prio_q[found_q ? best_q : used_q] <= preq_q;
              birth_q[found_q ? best_q : used_q] <= ctime_q;
              last_q <= '0;
              run_q <= '0;
              thread_id_o <= 5'(found_q ? best_q : used_q);
            end else begin
              status_o <= tts_pkg::StsFull;
            end
          end
          tts_pkg::ModeSchedule: begin
            if (last_q != '0 && state_q[last_q] == tts_pkg::StYield)
              state_q[last_q] <= tts_pkg::StRun;
            if (nxt_ok) begin
              run_q <= nxt;
              last_q <= nxt;
              thread_id_o <= 5'(nxt);
            end else begin
              status_o <= tts_pkg::StsNone;
            end
          end
          default: begin
            if (run_q == '0) begin
              status_o <= tts_pkg::StsIgnored;
            end else begin
              state_q[run_q] <= (mode_q == tts_pkg::ModeYield) ?
                                tts_pkg::StYield : tts_pkg::StFree;
              last_q <= run_q;
              run_q <= '0;
              thread_id_o <= 5'(run_q);
            end
          end
        endcase
      end
    end
  end
endmodule
